// File: src/life_pkg.sv
// Shared types and constants for the life grid generation core.
// No dependencies.
package life_pkg;

  localparam int MaxRows = 64;
  localparam int MaxCols = 128;
  localparam int RowW = 6;
  localparam int ColW = 7;
  localparam int AddrW = RowW + ColW;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_ADVANCE = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [1:0] REG_RULE = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_COLS = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic load_cmd;    // capture the accepted beat
    logic do_write;    // write the captured cell
    logic do_read;     // read the captured cell
    logic scan_start;  // clear scan counters
    logic scan_step;   // run one step of the advance sweep
    logic copy_start;  // clear copy counters
    logic copy_step;   // run one step of the copy sweep
    logic take_result; // load the output register
  } life_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;
    logic copy_done;
  } life_stat_t;

endpackage

// File: src/life_ctrl.sv
// Command sequencer for the life grid core.
// Depends on life_pkg.
module life_ctrl import life_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic       out_busy,
  input  life_stat_t stat,
  output life_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_COPY  = 6'b001000,
    S_RDWT  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [1:0] func_q;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    if (in_valid && in_ready) func_q <= func;
  end

  // Step through one command at a time.
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_cmd = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (func_q)
          FUNC_WRITE: begin
            cmd.do_write = 1'b1;
            state_next = S_DONE;
          end
          FUNC_READ: begin
            cmd.do_read = 1'b1;
            state_next = S_RDWT;
          end
          FUNC_ADVANCE: begin
            cmd.scan_start = 1'b1;
            state_next = S_SCAN;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          cmd.copy_start = 1'b1;
          state_next = S_COPY;
        end
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (stat.copy_done) state_next = S_DONE;
      end
      S_RDWT: state_next = S_DONE;
      S_DONE: begin
        if (!out_busy) begin
          cmd.take_result = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: src/life_dp.sv
// Grid memories, neighbor sweep and copy-back for the life grid core.
// Depends on life_pkg.
module life_dp import life_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  life_cmd_t        cmd,
  output life_stat_t       stat,
  input  logic [1:0]       func,
  input  logic [RowW-1:0]  row,
  input  logic [ColW-1:0]  col,
  input  logic             cell_in,
  input  logic             rule_q,
  input  logic [RowW:0]    nrows,
  input  logic [ColW:0]    ncols,
  output logic             res_cell,
  output logic             res_ack
);

  localparam int Depth = MaxRows * MaxCols;

  logic cur_mem [Depth];
  logic nxt_mem [Depth];

  logic [1:0]      func_q;
  logic [AddrW-1:0] addr_q;
  logic            cell_q;
  logic            rd_q;

  // Clearing sweep after reset and the sweep counters.
  logic            clr_busy;
  logic [AddrW:0]  clr_cnt;

  logic [RowW-1:0] r, ra;
  logic [ColW-1:0] c, ca;
  logic [3:0]      ph;        // neighbor phase 0..10; reads in 0..8
  logic            rd_valid;
  logic [3:0]      rd_ph;
  logic [3:0]      cnt;
  logic            alive;
  logic            scan_done_q, copy_done_q;
  logic            cp_valid;
  logic [AddrW-1:0] cp_addr;
  logic            nxt_rd;

  logic [RowW-1:0] r_up, r_dn;
  logic [ColW-1:0] c_lf, c_rt;
  logic            last_c, last_r;
  logic [3:0]      birth;
  logic            sweep_start, scan_go, copy_go;

  assign last_c = ({1'b0, c} == ncols - 1'b1);
  assign last_r = ({1'b0, r} == nrows - 1'b1);
  assign r_up = (r == '0) ? RowW'(nrows - 1'b1) : r - 1'b1;
  assign r_dn = last_r ? '0 : r + 1'b1;
  assign c_lf = (c == '0) ? ColW'(ncols - 1'b1) : c - 1'b1;
  assign c_rt = last_c ? '0 : c + 1'b1;
  assign birth = rule_q ? 4'd2 : 4'd3;

  // Qualify the sweep steps; a start takes precedence.
  assign sweep_start = cmd.scan_start || cmd.copy_start;
  assign scan_go = !sweep_start && cmd.scan_step && !scan_done_q;
  assign copy_go = !sweep_start && !scan_go && cmd.copy_step && !copy_done_q;

  // Pick the neighbor address for this phase; phase 4 is the center.
  always_comb begin
    case (ph)
      4'd0: begin ra = r_up; ca = c_lf; end
      4'd1: begin ra = r_up; ca = c;    end
      4'd2: begin ra = r_up; ca = c_rt; end
      4'd3: begin ra = r;    ca = c_lf; end
      4'd4: begin ra = r;    ca = c;    end
      4'd5: begin ra = r;    ca = c_rt; end
      4'd6: begin ra = r_dn; ca = c_lf; end
      4'd7: begin ra = r_dn; ca = c;    end
      default: begin ra = r_dn; ca = c_rt; end
    endcase
  end

  logic             cur_rd;
  logic             nxt_we;
  logic [AddrW-1:0] nxt_waddr;
  logic             nxt_wdata;
  logic             cell_next;

  always_comb begin
    cell_next = alive ? (cnt == 4'd2 || cnt == 4'd3) : (cnt == birth);
  end

  // Current grid: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      cur_mem[clr_cnt[AddrW-1:0]] <= 1'b0;
    end else if (cmd.do_write && func_q == FUNC_WRITE) begin
      cur_mem[addr_q] <= cell_q;
    end else if (cp_valid) begin
      cur_mem[cp_addr] <= nxt_rd;
    end
    if (cmd.do_read) cur_rd <= cur_mem[addr_q];
    else cur_rd <= cur_mem[{ra, ca}];
  end

  // Next grid: written by the sweep, read by the copy.
  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_waddr] <= nxt_wdata;
    nxt_rd <= nxt_mem[{r, c}];
  end

  // Capture the beat.
  always_ff @(posedge clk) begin
    if (cmd.load_cmd) begin
      func_q <= func;
      addr_q <= {row, col};
      cell_q <= cell_in;
    end
  end

  // Sweep sequencing for both the advance scan and the copy.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_cnt <= '0;
      ph <= '0;
      r <= '0;
      c <= '0;
      rd_valid <= 1'b0;
      cp_valid <= 1'b0;
      nxt_we <= 1'b0;
      scan_done_q <= 1'b0;
      copy_done_q <= 1'b0;
      rd_q <= 1'b0;
    end else begin
      rd_q <= cmd.do_read;
      nxt_we <= scan_go && (ph == 4'd10);
      cp_valid <= copy_go;
      rd_valid <= scan_go && (ph < 4'd9);
      if (clr_busy) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == (AddrW+1)'(Depth - 1)) clr_busy <= 1'b0;
      end
      if (sweep_start) begin
        ph <= '0;
        r <= '0;
        c <= '0;
        scan_done_q <= 1'b0;
        copy_done_q <= 1'b0;
      end else if (scan_go) begin
        // Nine reads per cell, then a write slot for the result.
        rd_ph <= ph;
        if (ph == 4'd10) begin
          ph <= '0;
          nxt_waddr <= {r, c};
          nxt_wdata <= cell_next;
          if (last_c) begin
            c <= '0;
            if (last_r) scan_done_q <= 1'b1;
            else r <= r + 1'b1;
          end else begin
            c <= c + 1'b1;
          end
        end else begin
          ph <= ph + 1'b1;
        end
      end else if (copy_go) begin
        // Read the next grid at (r,c) this cycle, write it back next cycle.
        cp_addr <= {r, c};
        if (last_c) begin
          c <= '0;
          if (last_r) copy_done_q <= 1'b1;
          else r <= r + 1'b1;
        end else begin
          c <= c + 1'b1;
        end
      end
    end
  end

  // Accumulate the neighbor count; phase 4 gives the cell itself.
  always_ff @(posedge clk) begin
    if (cmd.scan_start || (cmd.scan_step && ph == 4'd10)) begin
      cnt <= '0;
    end else if (rd_valid) begin
      if (rd_ph == 4'd4) alive <= cur_rd;
      else cnt <= cnt + {3'b0, cur_rd};
    end
  end

  // Output of the command.
  always_ff @(posedge clk) begin
    if (cmd.do_read || cmd.do_write || cmd.scan_start) begin
      res_ack <= 1'b1;
      res_cell <= 1'b0;
    end
    if (cmd.load_cmd) begin
      res_ack <= (func != FUNC_UNUSED);
      res_cell <= 1'b0;
    end
    if (rd_q) res_cell <= cur_rd;
  end

  assign stat.scan_done = scan_done_q;
  assign stat.copy_done = copy_done_q && !cp_valid;

endmodule

// File: src/life_grid_generation_core.sv
// Life grid generation core: 64x128 cell grid with B3/S23 or B2/S23 rule.
// Depends on life_pkg, life_ctrl and life_dp.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command beat: func, row,
//   col, cell_in. Write (0) stores one cell, read (2) returns one cell,
//   advance (1) computes one generation over the active area with toroidal
//   wrap. Code 3 changes nothing and answers ack 0.
//   Output channel (out_valid/out_ready) returns one beat per command with
//   cell_out and ack, held in an output register.
//   A write passes through the exec and done states, a read also through
//   the read-wait state, before its result is loaded. An advance runs a
//   neighbor sweep over each active cell (nine reads through the single
//   read port of the grid memory, then a result write) and then copies
//   each active cell back.
//   One command is in flight at a time; the next beat is taken once the
//   previous result has been loaded into the output register.
//   After reset a sweep clears all 8192 cells of the grid memory, during
//   which no command beat is accepted; configuration writes are taken always.
//   When the receiver stalls, the result waits in the output register; one
//   more command can be taken and run meanwhile, and its result is held back
//   until the register drains.
module life_grid_generation_core import life_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [7:0]      cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      func,
  input  logic [RowW-1:0] row,
  input  logic [ColW-1:0] col,
  input  logic            cell_in,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            cell_out,
  output logic            ack
);

  logic        rule_mode;
  logic [6:0]  rows_in_use;
  logic [7:0]  cols_in_use;
  logic [RowW:0] nrows;
  logic [ColW:0] ncols;
  life_cmd_t   cmd;
  life_stat_t  stat;
  logic        ctrl_ready;
  logic        res_cell, res_ack;
  logic        clr_wait;
  logic [AddrW:0] clr_cnt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_mode <= 1'b0;
      rows_in_use <= 7'd64;
      cols_in_use <= 8'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RULE: rule_mode <= cfg_data[0];
        REG_ROWS: rows_in_use <= cfg_data[6:0];
        REG_COLS: cols_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp bounds to 3..max.
  always_comb begin
    if (rows_in_use < 7'd3) nrows = (RowW+1)'(3);
    else if (rows_in_use > 7'(MaxRows)) nrows = (RowW+1)'(MaxRows);
    else nrows = rows_in_use;
    if (cols_in_use < 8'd3) ncols = (ColW+1)'(3);
    else if (cols_in_use > 8'(MaxCols)) ncols = (ColW+1)'(MaxCols);
    else ncols = cols_in_use;
  end

  // Hold off commands during the clearing sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_wait <= 1'b1;
      clr_cnt <= '0;
    end else if (clr_wait) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == (AddrW+1)'(MaxRows * MaxCols - 1)) clr_wait <= 1'b0;
    end
  end

  assign in_ready = ctrl_ready && !clr_wait;

  life_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid && !clr_wait),
    .in_ready (ctrl_ready),
    .func     (func),
    .out_busy (out_valid && !out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  life_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .func     (func),
    .row      (row),
    .col      (col),
    .cell_in  (cell_in),
    .rule_q   (rule_mode),
    .nrows    (nrows),
    .ncols    (ncols),
    .res_cell (res_cell),
    .res_ack  (res_ack)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.take_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.take_result) begin
      cell_out <= res_cell;
      ack <= res_ack;
    end
  end

endmodule

// File: src/life_checker.sv
// Port-level checks for the life grid generation core.
// Depends on life_pkg and binds to life_grid_generation_core.
module life_checker import life_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       cell_out,
  input logic       ack
);

  // Handshake outputs are always driven out of reset.
  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({in_ready, out_valid})) else $error("handshake output unknown");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_out) && $stable(ack))
    else $error("result changed while stalled");

  // Ready drops after each accepted beat.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready did not drop");

  // A live cell only comes with ack set.
  a_cell: assert property (@(posedge clk) disable iff (rst)
    out_valid && cell_out |-> ack) else $error("cell_out without ack");

endmodule

bind life_grid_generation_core life_checker u_life_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .cell_out  (cell_out),
  .ack       (ack)
);
